// ===== design/pulse_train_test_sequencer_assert.svh =====
// Assertion macros shared by the pulse train test sequencer RTL.
// Depends on nothing; included inside module bodies.
`ifndef PULSE_TRAIN_TEST_SEQUENCER_ASSERT_SVH
`define PULSE_TRAIN_TEST_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define PTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge out of reset.
`define PTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/pts_pkg.sv =====
// Package for the pulse train test sequencer: widths, codes, reset values,
// the configuration bundle type and the millisecond scaling function.
// Depends on nothing.
package pts_pkg;

    localparam int TIME_W     = 32;
    localparam int MS_W       = 16;
    localparam int US_PER_MS  = 1000;
    localparam int THR_W      = MS_W + $clog2(US_PER_MS);
    localparam int CNT_W      = 8;
    localparam int LVL_W      = 8;
    localparam int PH_W       = 3;
    localparam int REQ_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_FLD_W  = LVL_W + PH_W + 1 + 1 + CNT_W;
    localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_START = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STOP  = 2'd2;

    // Phase codes
    localparam logic [PH_W-1:0] PH_IDLE     = 3'd0;
    localparam logic [PH_W-1:0] PH_PREWAIT  = 3'd1;
    localparam logic [PH_W-1:0] PH_PULSE    = 3'd2;
    localparam logic [PH_W-1:0] PH_RECOVER  = 3'd3;
    localparam logic [PH_W-1:0] PH_FINISHED = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LEVEL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_MS       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_START_MS = 3'd4;

    // Register reset values
    localparam logic [CNT_W-1:0] RST_PULSE_COUNT  = 8'd10;
    localparam logic [LVL_W-1:0] RST_PULSE_LEVEL  = 8'd200;
    localparam logic [MS_W-1:0]  RST_PULSE_MS     = 16'd30;
    localparam logic [MS_W-1:0]  RST_GAP_MS       = 16'd1000;
    localparam logic [MS_W-1:0]  RST_PRE_START_MS = 16'd0;

    typedef logic [THR_W-1:0] t_thr;

    // Configuration as seen by the sequencer, thresholds already in microseconds.
    typedef struct packed {
        logic [CNT_W-1:0] count_eff;
        logic [LVL_W-1:0] level;
        t_thr             pulse_us;
        t_thr             gap_us;
        t_thr             pre_us;
    } t_cfg;

    // Milliseconds to microseconds; a constant multiply that fits THR_W exactly.
    function automatic t_thr scale_ms(input logic [MS_W-1:0] ms);
        return t_thr'({{(THR_W-MS_W){1'b0}}, ms}) * t_thr'(US_PER_MS);
    endfunction

endpackage

// ===== design/pts_cfg.sv =====
// Configuration register file for the pulse train test sequencer.
// Holds the effective count and level and the thresholds scaled to microseconds.
// Depends on pts_pkg.
module pts_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [pts_pkg::CFG_IDX_W-1:0]  i_wr_index,
    input  logic [pts_pkg::CFG_DATA_W-1:0] i_wr_data,
    output pts_pkg::t_cfg                 o_cfg
);
    import pts_pkg::*;

    logic [CNT_W-1:0] r_count_eff;
    logic [LVL_W-1:0] r_level;
    t_thr             r_pulse_us;
    t_thr             r_gap_us;
    t_thr             r_pre_us;

    logic [MS_W-1:0]  w_ms;
    logic [CNT_W-1:0] w_cnt;
    logic [MS_W-1:0]  w_pulse_ms_eff;

    assign w_ms  = i_wr_data[MS_W-1:0];
    assign w_cnt = i_wr_data[CNT_W-1:0];

    // A pulse time of zero behaves as one millisecond.
    assign w_pulse_ms_eff = (w_ms == '0) ? MS_W'(1) : w_ms;

    // Register writes; a pulse count of zero is stored as one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_eff <= RST_PULSE_COUNT;
            r_level     <= RST_PULSE_LEVEL;
            r_pulse_us  <= scale_ms(RST_PULSE_MS);
            r_gap_us    <= scale_ms(RST_GAP_MS);
            r_pre_us    <= scale_ms(RST_PRE_START_MS);
        end else if (i_wr_en) begin
            case (i_wr_index)
                CFG_PULSE_COUNT:  r_count_eff <= (w_cnt == '0) ? CNT_W'(1) : w_cnt;
                CFG_PULSE_LEVEL:  r_level     <= i_wr_data[LVL_W-1:0];
                CFG_PULSE_MS:     r_pulse_us  <= scale_ms(w_pulse_ms_eff);
                CFG_GAP_MS:       r_gap_us    <= scale_ms(w_ms);
                CFG_PRE_START_MS: r_pre_us    <= scale_ms(w_ms);
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = '{count_eff: r_count_eff, level: r_level,
                     pulse_us: r_pulse_us, gap_us: r_gap_us, pre_us: r_pre_us};

endmodule

// ===== design/pulse_train_test_sequencer.sv =====
// Top level of the pulse train test sequencer: request stream in, status stream out.
// Depends on pts_pkg, pts_cfg and pulse_train_test_sequencer_assert.svh.
//
//   Channel   Direction  Handshake                  Contents
//   s (req)   in         i_s_tvalid / o_s_tready    tuser req_type, tdata now_us
//   m (stat)  out        o_m_tvalid / i_m_tready    tdata status word
//   cfg       in         i_cfg_valid / o_cfg_ready  index, 16-bit data
//
// Each request word updates the state when accepted, and its status word is offered
// on the next cycle; a new request may be taken every cycle, also while the
// previous status word is taken in that same cycle. The sequencer state
// registers double as the status register, so a stalled output holds the
// request side back. Reset is synchronous and active low.
// Configuration writes are taken every cycle out of reset.
module pulse_train_test_sequencer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Request stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [pts_pkg::TIME_W-1:0]     i_s_tdata,  // [31:0] now_us
    input  logic [pts_pkg::REQ_W-1:0]      i_s_tuser,  // [1:0] req_type
    // Status stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [7:0] drive_level, [10:8] phase, [11] running, [12] done_res,
    // [20:13] pulses_started, [23:21] zero
    output logic [pts_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // Configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pts_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pts_pkg::*;
    `include "pulse_train_test_sequencer_assert.svh"

    t_cfg w_cfg;

    // Writes are held off while reset is applied.
    assign o_cfg_ready = i_rst_n;

    pts_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // Sequencer state, which is also the status word on offer
    logic              r_run,   n_run;
    logic              r_done,  n_done;
    logic [PH_W-1:0]   r_phase, n_phase;
    logic [CNT_W-1:0]  r_cnt,   n_cnt;
    logic [LVL_W-1:0]  r_drive, n_drive;
    logic [TIME_W-1:0] r_start, n_start;
    logic              r_out_valid;

    logic              w_accept;
    logic [TIME_W-1:0] w_elapsed;
    t_thr              w_thr;
    logic              w_reached;

    // The status slot frees up when empty or when its word is being taken.
    assign o_s_tready = i_rst_n && (!r_out_valid || i_m_tready);
    assign w_accept   = i_s_tvalid && o_s_tready;

    // Wrapping elapsed time against the threshold of the current phase.
    assign w_elapsed = i_s_tdata - r_start;

    always_comb begin
        case (r_phase)
            PH_PREWAIT: w_thr = w_cfg.pre_us;
            PH_PULSE:   w_thr = w_cfg.pulse_us;
            PH_RECOVER: w_thr = w_cfg.gap_us;
            default:    w_thr = '0;
        endcase
    end

    assign w_reached = w_elapsed >= {{(TIME_W-THR_W){1'b0}}, w_thr};

    // Next state for one request.
    always_comb begin
        n_run   = r_run;
        n_done  = r_done;
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_drive = r_drive;
        n_start = r_start;
        case (i_s_tuser)
            REQ_START: begin
                n_run   = 1'b1;
                n_done  = 1'b0;
                n_start = i_s_tdata;
                if (w_cfg.pre_us != '0) begin
                    n_phase = PH_PREWAIT;
                    n_cnt   = '0;
                    n_drive = '0;
                end else begin
                    // Effective count is at least one, so the first pulse counts.
                    n_phase = PH_PULSE;
                    n_cnt   = CNT_W'(1);
                    n_drive = w_cfg.level;
                end
            end
            REQ_STOP: begin
                n_run   = 1'b0;
                n_done  = 1'b0;
                n_phase = PH_IDLE;
                n_cnt   = '0;
                n_drive = '0;
                n_start = '0;
            end
            REQ_TICK: begin
                if (r_run) begin
                    case (r_phase)
                        PH_PREWAIT: begin
                            n_drive = '0;
                            if (w_reached) begin
                                if (r_cnt < w_cfg.count_eff) begin
                                    n_cnt = r_cnt + CNT_W'(1);
                                end
                                n_drive = w_cfg.level;
                                n_phase = PH_PULSE;
                                n_start = i_s_tdata;
                            end
                        end
                        PH_PULSE: begin
                            n_drive = w_cfg.level;
                            if (w_reached) begin
                                n_drive = '0;
                                n_phase = PH_RECOVER;
                                n_start = i_s_tdata;
                            end
                        end
                        PH_RECOVER: begin
                            n_drive = '0;
                            if (w_reached) begin
                                n_start = i_s_tdata;
                                if (r_cnt >= w_cfg.count_eff) begin
                                    n_run   = 1'b0;
                                    n_done  = 1'b1;
                                    n_phase = PH_FINISHED;
                                end else begin
                                    n_cnt   = r_cnt + CNT_W'(1);
                                    n_drive = w_cfg.level;
                                    n_phase = PH_PULSE;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    // State update on each accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
            r_drive <= '0;
            r_start <= '0;
        end else if (w_accept) begin
            r_run   <= n_run;
            r_done  <= n_done;
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_drive <= n_drive;
            r_start <= n_start;
        end
    end

    // Status word valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W-OUT_FLD_W){1'b0}}, r_cnt, r_done, r_run, r_phase, r_drive};

    `PTS_ASSERT_IMP(a_run_phase, i_clk, i_rst_n, r_run,
        (r_phase == PH_PREWAIT) || (r_phase == PH_PULSE) || (r_phase == PH_RECOVER),
        "running outside an active phase")
    `PTS_ASSERT_IMP(a_done_phase, i_clk, i_rst_n, r_done,
        (r_phase == PH_FINISHED) && !r_run, "done flag without finished phase")
    `PTS_ASSERT_IMP(a_idle_clear, i_clk, i_rst_n, r_phase == PH_IDLE,
        !r_run && !r_done && (r_cnt == '0) && (r_drive == '0), "idle with stale state")
    `PTS_ASSERT_NXT(a_stop_idle, i_clk, i_rst_n, w_accept && (i_s_tuser == REQ_STOP),
        (r_phase == PH_IDLE) && r_out_valid, "stop did not return to idle")

endmodule
